@@ hdl/smcd_pkg.sv @@
// constants, types and text lookup for the serial motor command decoder
`timescale 1ns / 1ps
`default_nettype none

package smcd_pkg;

   localparam int CMD_COUNT   = 6;
   localparam int CMD_MAX_LEN = 14;

   // command indexes, in match priority order
   typedef enum logic [2:0] {
      CMD_ON       = 3'd0,
      CMD_OFF      = 3'd1,
      CMD_FORWARD  = 3'd2,
      CMD_BACKWARD = 3'd3,
      CMD_ASC      = 3'd4,
      CMD_DESC     = 3'd5
   } cmd_type;

   // control characters
   localparam logic [7:0] CHAR_START = 8'h40;   // '@'
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_M     = 8'h4D;   // 'M', second ack character

   // command words, right-justified with zero fill
   localparam logic [8*CMD_MAX_LEN-1:0] CMD_TEXT [CMD_COUNT] = '{
      {"MOTOR_", "ON"}, {"MOTOR_", "OFF"}, {"MOTOR_", "FORWARD"},
      {"MOTOR_", "BACKWARD"}, {"MOTOR_", "ASC"}, {"MOTOR_", "DESC"}
   };
   localparam logic [3:0] CMD_LEN [CMD_COUNT] = '{
      4'd8, 4'd9, 4'd13, 4'd14, 4'd9, 4'd10
   };
   localparam logic [7:0] CMD_ACK [CMD_COUNT] = '{
      8'h4F, 8'h43, 8'h46, 8'h42, 8'h41, 8'h44   // O C F B A D
   };

   // speed levels
   localparam logic [6:0] LEVEL_ZERO = 7'd0;
   localparam logic [6:0] LEVEL_STEP = 7'd20;
   localparam logic [6:0] LEVEL_2    = 7'd40;
   localparam logic [6:0] LEVEL_3    = 7'd60;
   localparam logic [6:0] LEVEL_MAX  = 7'd80;

   // character p of command c, only meaningful for p below the command length
   function automatic logic [7:0] cmd_char(input int unsigned c, input logic [3:0] p);
      logic [8*CMD_MAX_LEN-1:0] txt;
      logic [3:0]               k;
      txt = CMD_TEXT[c];
      k   = CMD_LEN[c] - 4'd1 - p;
      return txt[8*k +: 8];
   endfunction

endpackage

`default_nettype wire

@@ hdl/serial_motor_command_decoder.sv @@
// serial motor command decoder: line matching, speed level and ack generation
`timescale 1ns / 1ps
`default_nettype none
// flow: a byte is held in the input register and decoded from it, waiting there while a
//   matched line feed finds the result register busy; the first ack is registered, the 'M' follows it
// throughput: one byte per cycle unless a matched line feed finds the result register busy;
//   a matched line feed holds the single result register for two transfers
// reset: synchronous, clears line position, overflow, speed level and all valid flags;
//   match flags come up all ones; no clearing pass

module serial_motor_command_decoder #(
   parameter int LINE_CAPACITY = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // [7:0] ack_char, [8] speed_update,
                                          // [16:9] speed_value, [23:17] zero
   output logic             rsp_tlast     // last
);
   import smcd_pkg::*;

   localparam int POS_W = $clog2(LINE_CAPACITY + 1);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;

   // line state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              ovf_ff, ovf_in;
   logic [CMD_COUNT-1:0] flags_ff, flags_in;
   logic [6:0]        level_ff, level_in;

   // result register and pending second ack
   logic              rsp_valid_ff, rsp_valid_in;
   logic              second_ff, second_in;
   logic [7:0]        ack_ff, ack_in;
   logic              upd_ff, upd_in;
   logic [7:0]        spd_ff, spd_in;
   logic              last_ff, last_in;

   // decode
   logic                  is_start, is_cr, is_lf;
   logic [CMD_COUNT-1:0]  keep;
   logic                  hit_found;
   cmd_type               hit;
   logic                  out_free, can_process, produces;
   logic                  upd_c;
   logic [6:0]            level_c;

   always_comb begin
      is_start = (in_byte_ff == CHAR_START);
      is_cr    = (in_byte_ff == CHAR_CR);
      is_lf    = (in_byte_ff == CHAR_LF);

      // a command stays live while the line is still a prefix of it
      for (int c = 0; c < CMD_COUNT; c++) begin
         keep[c] = (pos_ff < POS_W'(CMD_LEN[c])) &&
                   (cmd_char(c, pos_ff[3:0]) == in_byte_ff);
      end

      // lowest command index wins on a complete match
      hit_found = 1'b0;
      hit       = CMD_ON;
      for (int c = CMD_COUNT - 1; c >= 0; c--) begin
         if (flags_ff[c] && (pos_ff == POS_W'(CMD_LEN[c]))) begin
            hit_found = 1'b1;
            hit       = cmd_type'(3'(c));
         end
      end

      produces = is_lf && !ovf_ff && hit_found;
   end

   // result register can take a pair once nothing stays behind after this cycle
   assign out_free    = !rsp_valid_ff || (rsp_tready && !second_ff);
   assign can_process = in_valid_ff && (!produces || out_free);
   assign req_tready  = !in_valid_ff || can_process;

   // speed level step for the matched command
   always_comb begin
      upd_c   = 1'b1;
      level_c = level_ff;
      unique case (hit)
         CMD_ON, CMD_FORWARD, CMD_BACKWARD: level_c = LEVEL_STEP;
         CMD_OFF:                           level_c = LEVEL_ZERO;
         CMD_ASC: begin
            if (level_ff == LEVEL_STEP || level_ff == LEVEL_2 || level_ff == LEVEL_3) begin
               level_c = level_ff + LEVEL_STEP;
            end else begin
               upd_c = 1'b0;
            end
         end
         CMD_DESC: begin
            if (level_ff == LEVEL_STEP || level_ff == LEVEL_2 || level_ff == LEVEL_3 ||
                level_ff == LEVEL_MAX) begin
               level_c = level_ff - LEVEL_STEP;
            end else begin
               upd_c = 1'b0;
            end
         end
         default: upd_c = 1'b0;
      endcase
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      flags_in     = flags_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      second_in    = second_ff;
      ack_in       = ack_ff;
      upd_in       = upd_ff;
      spd_in       = spd_ff;
      last_in      = last_ff;

      // drain the result register, bringing up the trailing 'M'
      if (rsp_valid_ff && rsp_tready) begin
         if (second_ff) begin
            second_in = 1'b0;
            ack_in    = CHAR_M;
            upd_in    = 1'b0;
            spd_in    = 8'd0;
            last_in   = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end

      if (can_process) begin
         in_valid_in = 1'b0;
         priority if (is_start) begin
            pos_in   = '0;
            ovf_in   = 1'b0;
            flags_in = '1;
         end else if (is_cr) begin
            // ignored
         end else if (is_lf) begin
            if (produces) begin
               level_in     = level_c;
               rsp_valid_in = 1'b1;
               second_in    = 1'b1;
               ack_in       = CMD_ACK[hit];
               upd_in       = upd_c;
               spd_in       = upd_c ? {1'b0, level_c} : 8'd0;
               last_in      = 1'b0;
               // backward keeps the level as a magnitude
               if (hit == CMD_BACKWARD) begin
                  spd_in = 8'd0 - {1'b0, level_c};
               end
            end
         end else if (pos_ff >= POS_W'(LINE_CAPACITY)) begin
            // full line: saturate and poison it
            ovf_in = 1'b1;
         end else begin
            flags_in = flags_ff & keep;
            pos_in   = pos_ff + POS_W'(1);
         end
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         flags_ff     <= '1;
         level_ff     <= LEVEL_ZERO;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         flags_ff     <= flags_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      ack_ff  <= ack_in;
      upd_ff  <= upd_in;
      spd_ff  <= spd_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, spd_ff, upd_ff, ack_ff};
   assign rsp_tlast  = last_ff;

   // checks
   a_second_needs_valid: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> rsp_valid_ff)
      else $error("second ack pending without a held result");

   a_pair_completes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("first ack not followed by the closing ack");

   a_level_legal: assert property (@(posedge clock) disable iff (reset)
      level_ff == LEVEL_ZERO || level_ff == LEVEL_STEP || level_ff == LEVEL_2 ||
      level_ff == LEVEL_3 || level_ff == LEVEL_MAX)
      else $error("speed level off its grid");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (pos_ff == POS_W'(LINE_CAPACITY)))
      else $error("overflow flagged below capacity");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the serial motor command decoder
`timescale 1ns / 1ps

module testbench;
   import smcd_pkg::*;

   localparam int LINE_CAP    = 128;
   localparam int STUCK_LIMIT = 1000;   // cycles with no transfer on either side
   localparam int IDLE_PCT    = 37;
   localparam int SETTLE      = 20;     // cycles to wait after the last ack
   localparam string WORD_HEAD = "MOTOR_";

   // one acknowledge transfer as it leaves the block
   typedef struct packed {
      logic [7:0] ack_char;
      logic       speed_update;
      logic [7:0] speed_value;
      logic       last;
   } ack_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;             // [7:0] ack_char, [8] speed_update,
                                       // [16:9] speed_value, [23:17] zero
   logic        rsp_tlast;             // last

   // command words and first ack characters, indexed by cmd_type
   string      cmd_word [CMD_COUNT] = '{{WORD_HEAD, "ON"}, {WORD_HEAD, "OFF"},
                                        {WORD_HEAD, "FORWARD"}, {WORD_HEAD, "BACKWARD"},
                                        {WORD_HEAD, "ASC"}, {WORD_HEAD, "DESC"}};
   logic [7:0] ack_of   [CMD_COUNT] = '{"O", "C", "F", "B", "A", "D"};

   // shadow of the decoder state
   logic [7:0]           line_len;
   logic                 line_overrun;
   logic [CMD_COUNT-1:0] still_matching;
   logic [6:0]           motor_level;

   ack_result_type pending_acks [$];
   int          error_count;
   int          bytes_sent;
   int          stuck_cycles;
   logic        steady = 1'b0;        // no idling on either side while set

   serial_motor_command_decoder #(
      .LINE_CAPACITY (LINE_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      if (error_count < 40)
         $display("mismatch on %s: got %0d, expected %0d (at %0t)", what, got_v, want_v,
                  $time);
      error_count++;
   endtask

   // updates the shadow state for one accepted byte and queues the acks it causes
   function automatic void predict_byte(input logic [7:0] rx);
      int          hit;
      ack_result_type first_ack;
      ack_result_type second_ack;
      logic [7:0]  step8;
      hit   = -1;
      step8 = {1'b0, LEVEL_STEP};
      if (rx == CHAR_START) begin
         line_len       = '0;
         line_overrun   = 1'b0;
         still_matching = '1;
      end else if (rx == CHAR_CR) begin
         // carriage return leaves everything alone
      end else if (rx != CHAR_LF) begin
         if (line_len >= LINE_CAP) begin
            line_overrun = 1'b1;
         end else begin
            for (int c = 0; c < CMD_COUNT; c++)
               if (line_len >= cmd_word[c].len() || cmd_word[c][line_len] != rx)
                  still_matching[c] = 1'b0;
            line_len++;
         end
      end else if (!line_overrun) begin
         // line feed: first command, in priority order, that the whole line spells
         for (int c = 0; c < CMD_COUNT; c++)
            if (hit < 0 && still_matching[c] && line_len == cmd_word[c].len())
               hit = c;
         if (hit >= 0) begin
            first_ack          = '0;
            first_ack.ack_char = ack_of[hit];
            case (cmd_type'(hit[2:0]))
               CMD_ON, CMD_FORWARD: begin
                  motor_level = LEVEL_STEP;
                  first_ack.speed_update = 1'b1;
                  first_ack.speed_value  = step8;
               end
               CMD_OFF: begin
                  motor_level = LEVEL_ZERO;
                  first_ack.speed_update = 1'b1;
               end
               CMD_BACKWARD: begin
                  motor_level = LEVEL_STEP;
                  first_ack.speed_update = 1'b1;
                  first_ack.speed_value  = -step8;
               end
               CMD_ASC: begin
                  // no step up from stop or from the top level
                  if (motor_level != LEVEL_ZERO && motor_level != LEVEL_MAX) begin
                     motor_level = motor_level + LEVEL_STEP;
                     first_ack.speed_update = 1'b1;
                     first_ack.speed_value  = {1'b0, motor_level};
                  end
               end
               default: begin
                  if (motor_level != LEVEL_ZERO) begin
                     motor_level = motor_level - LEVEL_STEP;
                     first_ack.speed_update = 1'b1;
                     first_ack.speed_value  = {1'b0, motor_level};
                  end
               end
            endcase
            second_ack          = '0;
            second_ack.ack_char = CHAR_M;
            second_ack.last     = 1'b1;
            pending_acks.push_back(first_ack);
            pending_acks.push_back(second_ack);
         end
      end
   endfunction

   // byte transfers feed the shadow model, ack transfers are checked in order
   always @(posedge clock) begin : ack_checker
      ack_result_type want;
      if (reset) begin
         line_len       = '0;
         line_overrun   = 1'b0;
         still_matching = '1;
         motor_level    = LEVEL_ZERO;
      end else begin
         if (req_tvalid && req_tready)
            predict_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_acks.size() == 0) begin
               report_mismatch("unexpected ack, ack_char", rsp_tdata[7:0], -1);
            end else begin
               want = pending_acks.pop_front();
               if (rsp_tdata[7:0] != want.ack_char)
                  report_mismatch("ack_char", rsp_tdata[7:0], want.ack_char);
               if (rsp_tdata[8] != want.speed_update)
                  report_mismatch("speed_update", rsp_tdata[8], want.speed_update);
               if (rsp_tdata[16:9] != want.speed_value)
                  report_mismatch("speed_value", $signed(rsp_tdata[16:9]),
                                  $signed(want.speed_value));
               if (rsp_tlast != want.last)
                  report_mismatch("last", rsp_tlast, want.last);
               if (rsp_tdata[23:17] != '0)
                  report_mismatch("tdata fill bits", rsp_tdata[23:17], 0);
            end
         end
      end
      // receiver back-pressure
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // ends a run that has stopped moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no transfer for %0d cycles", STUCK_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // one byte transfer, with random idle cycles in front of it
   task automatic send_byte(input logic [7:0] rx);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++)
         send_byte(s[k]);
   endtask

   task automatic send_command(input cmd_type c);
      send_byte(CHAR_START);
      send_text(cmd_word[c]);
      send_byte(CHAR_LF);
   endtask

   // stops sending until every queued ack has been seen
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_acks.size() != 0);
   endtask

   // every command, with the level walked to both ends
   task automatic test_command_set();
      send_command(CMD_ASC);        // at stop: ack only
      send_command(CMD_DESC);       // at stop: ack only
      send_command(CMD_ON);
      send_command(CMD_ASC);
      send_command(CMD_ASC);
      send_command(CMD_ASC);        // reaches the top level
      send_command(CMD_ASC);        // at the top: ack only
      send_command(CMD_DESC);
      send_command(CMD_OFF);
      send_command(CMD_FORWARD);
      send_command(CMD_BACKWARD);
      send_command(CMD_DESC);       // magnitude back to stop
   endtask

   // line feed keeps the line, carriage return is dropped, odd bytes never match
   task automatic test_line_rules();
      send_byte(CHAR_START);
      send_byte(CHAR_LF);           // empty line
      send_text("MOTOR_O");
      send_byte(CHAR_LF);           // prefix only
      send_text("N");
      send_byte(CHAR_LF);           // same line now spells a command
      send_byte(CHAR_LF);           // and answers again
      send_byte(CHAR_START);
      send_text("MOTOR");
      send_byte(CHAR_CR);
      send_text("_OFF");
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      send_byte(CHAR_START);
      send_text("MOTOR_");
      send_byte(8'h00);
      send_text("N");
      send_byte(CHAR_LF);
      send_byte(CHAR_START);
      send_byte(8'hFF);
      send_byte(CHAR_LF);
      send_byte(CHAR_START);
      send_text("MOTOR_O");
      send_text("NX");
      send_byte(CHAR_LF);
   endtask

   // fills a line to capacity, which stays unmatched; '@' then recovers
   task automatic test_overflow();
      send_byte(CHAR_START);
      repeat (LINE_CAP) send_byte("A");
      send_byte(CHAR_LF);
      send_command(CMD_ON);
      send_command(CMD_FORWARD);
      send_command(CMD_DESC);
   endtask

   // sender waits for the block to drain between commands
   task automatic test_drain_pause();
      send_command(CMD_ON);
      hold_until_drained();
      send_command(CMD_ASC);
      hold_until_drained();
      send_command(CMD_BACKWARD);
   endtask

   // mostly well-formed command lines with random flaws, some noise and long lines
   task automatic send_random_line();
      int c;
      int wlen;
      int flaw;
      int bad_at;
      int cr_at;
      int cut_at;
      c      = $urandom_range(0, CMD_COUNT - 1);
      wlen   = cmd_word[c].len();
      flaw   = $urandom_range(0, 99);
      bad_at = -1;
      cr_at  = -1;
      cut_at = wlen;
      if (flaw < 8) begin
         repeat ($urandom_range(1, 16)) send_byte(8'($urandom_range(0, 255)));
      end else if (flaw < 10) begin
         send_byte(CHAR_START);
         repeat ($urandom_range(LINE_CAP - 2, LINE_CAP + 6))
            send_byte(8'($urandom_range("A", "Z")));
         send_byte(CHAR_LF);
      end else begin
         if (flaw >= 14)
            send_byte(CHAR_START);    // otherwise the line carries on
         if (flaw >= 14 && flaw < 28)
            bad_at = $urandom_range(0, wlen);
         if (flaw >= 28 && flaw < 34)
            cut_at = $urandom_range(0, wlen - 1);
         if (flaw >= 34 && flaw < 44)
            cr_at = $urandom_range(0, wlen - 1);
         for (int k = 0; k < cut_at; k++) begin
            if (k == cr_at)
               send_byte(CHAR_CR);
            if (k == bad_at)
               send_byte(8'($urandom_range(0, 255)));
            else
               send_byte(cmd_word[c][k]);
         end
         if (bad_at == wlen)
            send_byte(8'($urandom_range(0, 255)));
         send_byte(CHAR_LF);
         if ($urandom_range(0, 9) == 0)
            send_byte(CHAR_LF);
      end
   endtask

   task automatic test_random_traffic(input int byte_budget);
      int stop_at;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at)
         send_random_line();
   endtask

   // a stretch where neither side ever idles
   task automatic test_steady_stream(input int byte_budget);
      int stop_at;
      stop_at = bytes_sent + byte_budget;
      steady <= 1'b1;
      while (bytes_sent < stop_at)
         send_random_line();
      steady <= 1'b0;
   endtask

   initial begin
      error_count = 0;
      bytes_sent  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_command_set();
      test_line_rules();
      test_overflow();
      test_drain_pause();
      test_random_traffic(250);
      test_steady_stream(120);
      test_random_traffic(30);

      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
      if (pending_acks.size() != 0)
         report_mismatch("acks still outstanding", 0, pending_acks.size());
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/smcd_pkg.sv
hdl/serial_motor_command_decoder.sv
tb/testbench.sv
